// ===== sv/ttcb_pkg.sv =====
// Shared types, constants and codes of the text terminal cell buffer.
`timescale 1ns / 1ps
package ttcb_pkg;
	localparam int MaxRowsDef    = 64;
	localparam int MaxColumnsDef = 128;
	localparam logic [7:0] ChNewline = 8'h0A;
	localparam logic [7:0] ChReturn  = 8'h0D;
	localparam logic [7:0] ChBlank   = 8'h20;

	typedef enum logic [1:0] {
		CMD_PUT   = 2'd0,
		CMD_READ  = 2'd1,
		CMD_FLUSH = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_COLUMNS = 2'd0,
		REG_ROWS    = 2'd1,
		REG_HWSCROLL = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data_byte;
		logic [5:0] cell_row;
		logic [6:0] cell_column;
		logic       clear_dirty;
	} req_t;

	typedef struct packed {
		logic       wrote_cell;
		logic       scrolled;
		logic [5:0] cursor_row;
		logic [7:0] cursor_column;
		logic [7:0] cell_char;
		logic       cell_dirty;
		logic       line_dirty;
		logic       line_continues;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_RD_WAIT,
		ST_RD_DONE,
		ST_PUT_WR,
		ST_SC_RD,
		ST_SC_WAIT,
		ST_SC_WR,
		ST_SC_BLANK,
		ST_SC_LINE,
		ST_RESP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_step;     // write blank/dirty at the sweep address, advance it
		logic take_req;     // latch the request and clamp the cursor
		logic rd_issue;     // issue memory read of the requested cell
		logic rd_finish;    // capture read data, optionally clear dirty
		logic put_write;    // store the byte at the cursor
		logic nl_start;     // start a newline (column 0, row + 1 or scroll)
		logic cr_only;      // carriage return
		logic sc_read;      // read source cell of scroll
		logic sc_write;     // write destination cell of scroll, advance
		logic sc_blank;     // blank one cell of the bottom row, advance
		logic sc_line;      // shift the line flags and finish the scroll
		logic flush;        // clear the line dirty flags
		logic load_rsp;     // load the output register
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_done;
		logic [1:0] cmd;
		logic is_nl;
		logic is_cr;
		logic need_wrap;
		logic read_ok;
		logic will_scroll;
		logic sc_row_last;   // last column of the last source row
		logic blank_last;
		logic no_src_rows;   // single row: nothing to move
	} sts_t;
endpackage

// ===== sv/ttcb_ram.sv =====
// Generic single port RAM with registered read.
`timescale 1ns / 1ps
module ttcb_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== sv/ttcb_ctrl.sv =====
// Controller state machine of the text terminal cell buffer.
`timescale 1ns / 1ps
module ttcb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  ttcb_pkg::sts_t sts,
	output ttcb_pkg::ctl_t ctl
);
	import ttcb_pkg::*;

	state_t state_q, state_next;
	logic   out_valid_q;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_done) state_next = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_next = ST_DECODE;
			end
			ST_DECODE: begin
				case (sts.cmd)
					CMD_PUT: begin
						if (sts.is_cr) state_next = ST_RESP;
						else if (sts.is_nl || sts.need_wrap) begin
							if (!sts.will_scroll) state_next = sts.is_nl ? ST_RESP : ST_PUT_WR;
							else if (sts.no_src_rows) state_next = ST_SC_BLANK;
							else state_next = ST_SC_RD;
						end else state_next = ST_PUT_WR;
					end
					CMD_READ: state_next = sts.read_ok ? ST_RD_WAIT : ST_RESP;
					default:  state_next = ST_RESP;
				endcase
			end
			ST_RD_WAIT:  state_next = ST_RD_DONE;
			ST_RD_DONE:  state_next = ST_RESP;
			ST_PUT_WR:   state_next = ST_RESP;
			ST_SC_RD:    state_next = ST_SC_WAIT;
			ST_SC_WAIT:  state_next = ST_SC_WR;
			ST_SC_WR:    state_next = sts.sc_row_last ? ST_SC_BLANK : ST_SC_RD;
			ST_SC_BLANK: begin
				if (sts.blank_last) state_next = ST_SC_LINE;
			end
			ST_SC_LINE:  state_next = sts.is_nl ? ST_RESP : ST_PUT_WR;
			ST_RESP: begin
				if (!out_valid_q || out_ready) state_next = ST_IDLE;
			end
			default:     state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			ST_CLEAR:    ctl.clr_step = 1'b1;
			ST_IDLE:     ctl.take_req = in_valid;
			ST_DECODE: begin
				ctl.rd_issue = (sts.cmd == CMD_READ) && sts.read_ok;
				ctl.nl_start = (sts.cmd == CMD_PUT) && !sts.is_cr && (sts.is_nl || sts.need_wrap);
				ctl.cr_only  = (sts.cmd == CMD_PUT) && sts.is_cr;
				ctl.flush    = (sts.cmd == CMD_FLUSH);
			end
			ST_RD_WAIT:  ctl.rd_issue = 1'b1;
			ST_RD_DONE:  ctl.rd_finish = 1'b1;
			ST_PUT_WR:   ctl.put_write = 1'b1;
			ST_SC_RD:    ctl.sc_read = 1'b1;
			ST_SC_WR:    ctl.sc_write = 1'b1;
			ST_SC_BLANK: ctl.sc_blank = 1'b1;
			ST_SC_LINE:  ctl.sc_line = 1'b1;
			ST_RESP:     ctl.load_rsp = !out_valid_q || out_ready;
			default:     ctl = '0;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (ctl.load_rsp) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Accept only in idle, and never during the clearing pass.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_DECODE))
		else $error("accept did not start decode");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_rsp |=> out_valid)
		else $error("response load lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !in_ready)
		else $error("accept during clear");
endmodule

// ===== sv/ttcb_datapath.sv =====
// Datapath: cell memories, line flags, cursor and sweep counters.
`timescale 1ns / 1ps
module ttcb_datapath #(
	parameter int MaxRows    = ttcb_pkg::MaxRowsDef,
	parameter int MaxColumns = ttcb_pkg::MaxColumnsDef
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ttcb_pkg::req_t  req,
	input  ttcb_pkg::ctl_t  ctl,
	output ttcb_pkg::sts_t  sts,
	output ttcb_pkg::rsp_t  rsp,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_idx,
	input  logic [7:0]      cfg_wdata,
	output logic [7:0]      columns_q_o,
	output logic [6:0]      rows_q_o,
	output logic            hw_scroll_o
);
	import ttcb_pkg::*;

	localparam int RowW  = $clog2(MaxRows);
	localparam int ColW  = $clog2(MaxColumns);
	localparam int Cells = MaxRows * MaxColumns;
	localparam int AddrW = RowW + ColW;
	localparam int RcntW = $clog2(MaxRows + 1);
	localparam int CcntW = $clog2(MaxColumns + 1);

	logic [7:0] columns_q;
	logic [6:0] rows_q;
	logic       hw_scroll_q;
	logic [CcntW-1:0] cols_now;
	logic [RcntW-1:0] rows_now;

	req_t  req_q;
	logic [RowW-1:0]  row_q;
	logic [CcntW-1:0] col_q;
	logic [RowW-1:0]  srow_q;   // destination row of scroll sweep
	logic [ColW-1:0]  scol_q;
	logic [AddrW:0]   clr_q;
	logic             scrolled_q;
	logic             by_wrap_q;
	logic             wrote_q;
	logic             clamp_pend_q;
	logic [MaxRows-1:0] ldirty_q, lcont_q;
	logic [MaxRows-1:0] lcont_nl, lcont_sc, ldirty_sc;
	logic [7:0] rd_char_q;
	logic       rd_cdirty_q, rd_ldirty_q, rd_lcont_q;
	rsp_t       rsp_q;

	logic [AddrW-1:0] addr;
	logic             we;
	logic             cd_we;
	logic [7:0]       ch_wdata, ch_rdata;
	logic             cd_wdata, cd_rdata;
	logic [7:0]       byte_cap_q;

	// Effective geometry, held within the supported range.
	always_comb begin
		if (columns_q == 8'd0) cols_now = CcntW'(1);
		else if (32'(columns_q) > MaxColumns) cols_now = CcntW'(MaxColumns);
		else cols_now = CcntW'(columns_q);
		if (rows_q == 7'd0) rows_now = RcntW'(1);
		else if (32'(rows_q) > MaxRows) rows_now = RcntW'(MaxRows);
		else rows_now = RcntW'(rows_q);
	end

	logic [RowW-1:0] last_row;
	assign last_row = RowW'(rows_now - RcntW'(1));

	logic last_col_s;
	assign last_col_s = (CcntW'(scol_q) == cols_now - CcntW'(1));

	always_comb begin
		sts = '0;
		sts.clr_done    = clr_q[AddrW];
		sts.cmd         = req_q.cmd;
		sts.is_nl       = req_q.data_byte == ChNewline;
		sts.is_cr       = req_q.data_byte == ChReturn;
		sts.need_wrap   = col_q >= cols_now;
		sts.read_ok     = (32'(req_q.cell_row) < 32'(rows_now))
			&& (32'(req_q.cell_column) < 32'(cols_now));
		sts.will_scroll = row_q == last_row;
		sts.sc_row_last = last_col_s && (srow_q == RowW'(rows_now - RcntW'(2)));
		sts.blank_last  = last_col_s;
		sts.no_src_rows = rows_now == RcntW'(1);
	end

	// Next line flags for a newline without scroll and for the end of a scroll.
	always_comb begin
		lcont_nl = lcont_q;
		lcont_nl[0] = 1'b0;
		lcont_nl[row_q + RowW'(1)] = !sts.is_nl;
		lcont_sc  = lcont_q;
		ldirty_sc = ldirty_q;
		for (int r = 0; r < MaxRows - 1; r++) begin
			if (32'(r + 1) < 32'(rows_now)) begin
				lcont_sc[r] = lcont_q[r + 1];
				if (!hw_scroll_q) ldirty_sc[r] = 1'b1;
			end
		end
		ldirty_sc[last_row] = 1'b1;
		lcont_sc[0]         = 1'b0;
		lcont_sc[last_row]  = by_wrap_q;
	end

	// Memory address, write enable and data.
	always_comb begin
		addr     = '0;
		we       = 1'b0;
		ch_wdata = ChBlank;
		cd_wdata = 1'b1;
		if (ctl.clr_step) begin
			addr = clr_q[AddrW-1:0];
			we   = 1'b1;
		end else if (ctl.rd_issue || ctl.rd_finish) begin
			addr = {RowW'(req_q.cell_row), ColW'(req_q.cell_column)};
			we   = ctl.rd_finish && req_q.clear_dirty;
			ch_wdata = ch_rdata;
			cd_wdata = 1'b0;
		end else if (ctl.put_write) begin
			addr = {row_q, ColW'(col_q)};
			we   = 1'b1;
			ch_wdata = req_q.data_byte;
		end else if (ctl.sc_read) begin
			addr = {RowW'(srow_q + RowW'(1)), scol_q};
		end else if (ctl.sc_write) begin
			addr = {srow_q, scol_q};
			we   = 1'b1;
			ch_wdata = byte_cap_q;
		end else if (ctl.sc_blank) begin
			addr = {last_row, scol_q};
			we   = 1'b1;
		end
	end

	// With hardware scroll a moved cell keeps the dirty flag of its destination.
	assign cd_we = we && !(ctl.sc_write && hw_scroll_q);

	ttcb_ram #(.Width(8), .Depth(Cells)) u_char (
		.clk(clk), .we(we), .addr(addr), .wdata(ch_wdata), .rdata(ch_rdata));
	ttcb_ram #(.Width(1), .Depth(Cells)) u_dirty (
		.clk(clk), .we(cd_we), .addr(addr), .wdata(cd_wdata), .rdata(cd_rdata));

	// Capture the source character of a scroll move.
	logic sc_wait_q;

	always_ff @(posedge clk) begin
		sc_wait_q <= ctl.sc_read;
		if (sc_wait_q) byte_cap_q <= ch_rdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q    <= 8'd80;
			rows_q       <= 7'd25;
			hw_scroll_q  <= 1'b0;
			row_q        <= '0;
			col_q        <= '0;
			clr_q        <= '0;
			ldirty_q     <= '1;
			lcont_q      <= '0;
			srow_q       <= '0;
			scol_q       <= '0;
			scrolled_q   <= 1'b0;
			by_wrap_q    <= 1'b0;
			wrote_q      <= 1'b0;
			clamp_pend_q <= 1'b0;
		end else begin
			if (ctl.clr_step) clr_q <= clr_q + (AddrW+1)'(1);
			clamp_pend_q <= cfg_we;
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_COLUMNS:  columns_q   <= cfg_wdata;
					REG_ROWS:     rows_q      <= cfg_wdata[6:0];
					REG_HWSCROLL: hw_scroll_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			// Pull the cursor into the geometry after a register write and on each accepted request.
			if (ctl.take_req || clamp_pend_q) begin
				if (32'(row_q) > 32'(last_row)) row_q <= last_row;
				if (col_q > cols_now) col_q <= cols_now;
			end
			if (ctl.take_req) begin
				scrolled_q <= 1'b0;
				wrote_q    <= 1'b0;
			end
			if (ctl.cr_only) col_q <= '0;
			if (ctl.nl_start) begin
				col_q     <= '0;
				by_wrap_q <= !sts.is_nl;
				scol_q    <= '0;
				srow_q    <= '0;
				if (!sts.will_scroll) begin
					row_q   <= row_q + RowW'(1);
					lcont_q <= lcont_nl;
				end else scrolled_q <= 1'b1;
			end
			if (ctl.sc_write) begin
				if (last_col_s) begin
					scol_q <= '0;
					srow_q <= srow_q + RowW'(1);
				end else scol_q <= scol_q + ColW'(1);
			end
			if (ctl.sc_blank) scol_q <= last_col_s ? '0 : scol_q + ColW'(1);
			if (ctl.sc_line) begin
				lcont_q  <= lcont_sc;
				ldirty_q <= ldirty_sc;
			end
			if (ctl.put_write) begin
				ldirty_q[row_q] <= 1'b1;
				col_q   <= col_q + CcntW'(1);
				wrote_q <= 1'b1;
			end
			if (ctl.flush) ldirty_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take_req) req_q <= req;
		if (ctl.rd_issue) begin
			rd_ldirty_q <= ldirty_q[RowW'(req_q.cell_row)];
			rd_lcont_q  <= lcont_q[RowW'(req_q.cell_row)];
		end
		if (ctl.rd_finish) begin
			rd_char_q   <= ch_rdata;
			rd_cdirty_q <= cd_rdata;
		end
		if (ctl.load_rsp) begin
			rsp_q.wrote_cell    <= wrote_q;
			rsp_q.scrolled      <= scrolled_q;
			rsp_q.cursor_row    <= 6'(row_q);
			rsp_q.cursor_column <= 8'(col_q);
			if (req_q.cmd == CMD_READ && sts.read_ok) begin
				rsp_q.cell_char      <= rd_char_q;
				rsp_q.cell_dirty     <= rd_cdirty_q;
				rsp_q.line_dirty     <= rd_ldirty_q;
				rsp_q.line_continues <= rd_lcont_q;
			end else begin
				rsp_q.cell_char      <= '0;
				rsp_q.cell_dirty     <= 1'b0;
				rsp_q.line_dirty     <= 1'b0;
				rsp_q.line_continues <= 1'b0;
			end
		end
	end

	assign rsp         = rsp_q;
	assign columns_q_o = columns_q;
	assign rows_q_o    = rows_q;
	assign hw_scroll_o = hw_scroll_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.put_write |-> (col_q < cols_now))
		else $error("put outside the row");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.sc_line |=> (row_q == last_row))
		else $error("cursor left bottom row after scroll");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.flush |=> (ldirty_q == '0))
		else $error("flush incomplete");
endmodule

// ===== sv/text_terminal_cell_buffer.sv =====
// Top level of the text terminal cell buffer.
`timescale 1ns / 1ps
// Character-cell terminal buffer. One request at a time, from the accepting
// cycle until the controller is idle again: a read of a cell on screen passes
// the decode, read wait, read done and response states, a put that stores a
// byte passes decode, put write and response, and a flush, carriage return,
// newline without scroll, off-screen read or unused command passes decode and
// response. The response register holds the result until it is taken; the next
// request may be accepted meanwhile but waits in the response state until the
// held one drains. A put or newline that scrolls walks the cell memory through
// its single port: each moved cell passes a read, a wait and a write state, each
// blanked cell of the bottom row the blank state, and a put that wraps and
// scrolls then stores its byte. After reset a clearing pass writes every one of
// MaxRows*MaxColumns cells and holds in_ready low until it is done. Write
// registers only while no request is in flight; the cursor is pulled back into
// the new geometry after the write, and again on each accepted request.
module text_terminal_cell_buffer #(
	parameter int MaxRows    = ttcb_pkg::MaxRowsDef,
	parameter int MaxColumns = ttcb_pkg::MaxColumnsDef
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ttcb_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output ttcb_pkg::rsp_t out_data,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [3:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	import ttcb_pkg::*;

	localparam logic [1:0] REG_NONE_IDX = 2'd3;

	ctl_t ctl;
	sts_t sts;
	logic       cfg_we;
	logic [7:0] columns_q;
	logic [6:0] rows_q;
	logic       hw_scroll;

	// Write on the access phase; pready is always high.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[3:2] != REG_NONE_IDX);

	// Read back the selected register.
	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_COLUMNS:  prdata = 32'(columns_q);
			REG_ROWS:     prdata = 32'(rows_q);
			REG_HWSCROLL: prdata = 32'(hw_scroll);
			default:      prdata = '0;
		endcase
	end

	ttcb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .ctl(ctl));

	ttcb_datapath #(.MaxRows(MaxRows), .MaxColumns(MaxColumns)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(in_data), .ctl(ctl), .sts(sts),
		.rsp(out_data), .cfg_we(cfg_we), .cfg_idx(paddr[3:2]),
		.cfg_wdata(pwdata[7:0]), .columns_q_o(columns_q), .rows_q_o(rows_q),
		.hw_scroll_o(hw_scroll));

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("response changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second request taken while one is in flight");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !ctl.put_write)
		else $error("write while idle");
endmodule
